// ----- sv/chs_pkg.sv -----
// chs_pkg: item types, operation and status codes for the chained hash set.
// Depends on nothing; imported by chained_hash_set_unit and its testbench.
package chs_pkg;

  localparam int CFG_W  = 4;
  localparam int MODE_W = 2;
  localparam int IN_KEY_W = 32;
  localparam int STAT_W = 2;

  localparam logic [CFG_W-1:0] INDEX_BITS_RESET = 4'd4;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOCHANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [IN_KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic              present;
    logic [STAT_W-1:0] status;
  } out_item_t;

endpackage

// ----- sv/chs_ram.sv -----
// chs_ram: synchronous single-write, single-read memory with per-lane write enables.
// Read data registered. No package dependency.
module chs_ram #(
  parameter int DEPTH  = 256,
  parameter int LANES  = 8,
  parameter int LANE_W = 32
) (
  input  logic                      clk,
  input  logic [LANES-1:0]          we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  logic [LANES*LANE_W-1:0]   wdata,
  input  logic                      re,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output logic [LANES*LANE_W-1:0]   rdata
);

  logic [LANES*LANE_W-1:0] mem [DEPTH];
  logic [LANES*LANE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (we[l]) begin
        mem[waddr][l*LANE_W +: LANE_W] <= wdata[l*LANE_W +: LANE_W];
      end
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/chs_row_match.sv -----
// chs_row_match: compares a key against every slot of one bucket row.
// Gives the lowest matching valid slot and the lowest free slot, one-hot.
module chs_row_match #(
  parameter int DEPTH = 8,
  parameter int KW    = 32
) (
  input  logic [DEPTH*KW-1:0] row_keys,
  input  logic [DEPTH-1:0]    row_valid,
  input  logic [KW-1:0]       key,
  output logic [DEPTH-1:0]    hit_oh,
  output logic [DEPTH-1:0]    free_oh
);

  logic [DEPTH-1:0] hit_vec;
  logic [DEPTH-1:0] free_vec;

  always_comb begin
    for (int s = 0; s < DEPTH; s++) begin
      hit_vec[s] = row_valid[s] && (row_keys[s*KW +: KW] == key);
    end
    free_vec = ~row_valid;
  end

  // isolate lowest set bit
  assign hit_oh  = hit_vec & (~hit_vec + DEPTH'(1));
  assign free_oh = free_vec & (~free_vec + DEPTH'(1));

endmodule

// ----- sv/chained_hash_set_unit.sv -----
// chained_hash_set_unit: set of keys in power-of-two buckets, insert/lookup/erase.
// Uses chs_pkg, chs_ram (key rows, slot valid masks) and chs_row_match.
//
//  channel | ports                         | moves
//  --------+-------------------------------+---------------------------------
//  input   | in_valid, in_ready, in_data   | item: mode, key
//  result  | out_valid, out_ready, out_data| item: present, status
//  config  | cfg_we, cfg_wdata             | index_bits, no wait, no read-back
//
// For each item, at acceptance the bucket row and its valid mask
// are read from the two memories; the EXEC state then compares all slots and
// writes back. Items do not overlap, so same-bucket accesses never collide.
// After reset and after every cfg write the valid memory is swept clear,
// all MAX_BUCKETS rows, with in_ready low. If a result is still held on the
// output, the compare cycle waits (no write) until the output frees up.
module chained_hash_set_unit
  import chs_pkg::*;
#(
  parameter int MAX_BUCKETS  = 256,
  parameter int BUCKET_DEPTH = 8,
  parameter int KEY_WIDTH    = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W    = $clog2(MAX_BUCKETS);
  localparam int TOP_BITS = $clog2(MAX_BUCKETS + 1) - 1;  // floor(log2)
  localparam int KW       = (KEY_WIDTH < IN_KEY_W) ? KEY_WIDTH : IN_KEY_W;
  localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(MAX_BUCKETS - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  function automatic logic [CFG_W-1:0] clamp_bits(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] b;
    b = v;
    if (b < CFG_W'(1)) b = CFG_W'(1);
    if (b > CFG_W'(TOP_BITS)) b = CFG_W'(TOP_BITS);
    return b;
  endfunction

  logic [1:0]        state_r;
  logic [IDX_W-1:0]  clr_cnt_r;
  logic [CFG_W-1:0]  index_bits_r;
  logic [MODE_W-1:0] mode_r;
  logic [KW-1:0]     key_r;
  logic [IDX_W-1:0]  bucket_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [KW-1:0]     key_in;
  logic [IDX_W-1:0]  bucket_in;
  logic [IDX_W-1:0]  idx_mask;
  logic              accept;
  logic              commit;

  logic [BUCKET_DEPTH*KW-1:0] row_keys;
  logic [BUCKET_DEPTH-1:0]    row_valid;
  logic [BUCKET_DEPTH-1:0]    hit_oh;
  logic [BUCKET_DEPTH-1:0]    free_oh;

  logic                    hit;
  logic                    has_free;
  logic [BUCKET_DEPTH-1:0] key_we;
  logic                    vld_we;
  logic [IDX_W-1:0]        vld_waddr;
  logic [BUCKET_DEPTH-1:0] vld_wdata;
  out_item_t               result;

  // key masked to the stored width; bucket is its low index_bits bits
  assign key_in = in_data.key[KW-1:0];

  always_comb begin
    for (int i = 0; i < IDX_W; i++) begin
      idx_mask[i] = (CFG_W'(i) < index_bits_r);
    end
  end

  assign bucket_in = key_in[IDX_W-1:0] & idx_mask;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  // compare cycle may finish only when the output register is free
  assign commit   = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  chs_ram #(
    .DEPTH (MAX_BUCKETS),
    .LANES (BUCKET_DEPTH),
    .LANE_W(KW)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(bucket_r),
    .wdata({BUCKET_DEPTH{key_r}}),
    .re   (accept),
    .raddr(bucket_in),
    .rdata(row_keys)
  );

  chs_ram #(
    .DEPTH (MAX_BUCKETS),
    .LANES (1),
    .LANE_W(BUCKET_DEPTH)
  ) u_valid_ram (
    .clk  (clk),
    .we   (vld_we),
    .waddr(vld_waddr),
    .wdata(vld_wdata),
    .re   (accept),
    .raddr(bucket_in),
    .rdata(row_valid)
  );

  chs_row_match #(
    .DEPTH(BUCKET_DEPTH),
    .KW   (KW)
  ) u_match (
    .row_keys (row_keys),
    .row_valid(row_valid),
    .key      (key_r),
    .hit_oh   (hit_oh),
    .free_oh  (free_oh)
  );

  assign hit      = |hit_oh;
  assign has_free = |free_oh;

  // operation decode and write-back
  always_comb begin
    key_we         = '0;
    vld_we         = 1'b0;
    vld_waddr      = bucket_r;
    vld_wdata      = row_valid;
    result.present = hit;
    result.status  = ST_DONE;
    case (mode_r)
      MODE_INSERT: begin
        if (hit) begin
          result.status = ST_NOCHANGE;
        end else if (!has_free) begin
          result.status = ST_FULL;
        end else begin
          key_we    = commit ? free_oh : '0;
          vld_we    = commit;
          vld_wdata = row_valid | free_oh;
        end
      end
      MODE_ERASE: begin
        if (hit) begin
          vld_we    = commit;
          vld_wdata = row_valid & ~hit_oh;
        end else begin
          result.status = ST_NOCHANGE;
        end
      end
      default: begin
        // lookup, and the unused mode code behaves as lookup
        result.status = ST_DONE;
      end
    endcase
    if (state_r == S_CLEAR) begin
      vld_we    = 1'b1;
      vld_waddr = clr_cnt_r;
      vld_wdata = '0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      index_bits_r <= clamp_bits(INDEX_BITS_RESET);
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + IDX_W'(1);
          if (clr_cnt_r == LAST_ROW) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_CLEAR;
        end
      endcase
      if (cfg_we) begin
        index_bits_r <= clamp_bits(cfg_wdata);
        state_r      <= S_CLEAR;
        clr_cnt_r    <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_data.mode;
      key_r    <= key_in;
      bucket_r <= bucket_in;
    end
    if (commit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- dv/tb_chained_hash_set_unit.sv -----
// Self-checking testbench for chained_hash_set_unit: a directed table, then random phases.
// Each random phase sets a bucket count. Answers are checked against a behavioral set model or fixed table rows.
// Depends on chs_pkg and the chained_hash_set_unit RTL.
`timescale 1ns / 1ps

module tb_chained_hash_set_unit;
  import chs_pkg::*;

  localparam int NUM_BUCKETS    = 256;
  localparam int SLOTS          = 8;
  localparam int MAX_INDEX_BITS = 8;
  localparam int RESET_CYCLES   = 9;
  localparam int SETTLE_CYCLES  = 8;     // wait after the last answer before going on
  localparam int PHASE_ITEMS    = 136;
  localparam int POOL_SIZE      = 40;    // over 4 buckets: more keys than slots
  localparam int CALM_PHASE     = 4;     // phase run with no gaps on either side
  localparam longint WATCHDOG_NS = 64'd20_000_000;

  // Mode three has no meaning in the block; it behaves as a lookup.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // Rows with typed == 1 carry an answer that follows directly from the set semantics.
  // All other rows are checked against the model.
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [IN_KEY_W-1:0] key;
    bit                  typed;
    logic                present;
    logic [STAT_W-1:0]   status;
  } dir_row_t;

  // Reset setting is 16 buckets. Keys ending in hex 0 all map to bucket 0.
  // All-ones maps to bucket 15.
  localparam dir_row_t DIR_ROWS [25] = '{
    '{MODE_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, ST_DONE},      // empty after reset
    '{MODE_ERASE,  32'hFFFF_FFFF, 1'b1, 1'b0, ST_NOCHANGE},  // erase of absent key
    '{MODE_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_DONE},
    '{MODE_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_NOCHANGE},  // already stored
    '{MODE_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_DONE},
    '{MODE_SPARE,  32'hFFFF_FFFF, 1'b1, 1'b1, ST_DONE},      // spare mode looks up
    '{MODE_SPARE,  32'h0000_0000, 1'b1, 1'b0, ST_DONE},
    '{MODE_INSERT, 32'h0000_0000, 1'b1, 1'b0, ST_DONE},      // fill bucket 0 ...
    '{MODE_INSERT, 32'h0000_0010, 1'b0, 1'b0, ST_DONE},
    '{MODE_INSERT, 32'h8000_0000, 1'b0, 1'b0, ST_DONE},
    '{MODE_INSERT, 32'h7FFF_FFF0, 1'b0, 1'b0, ST_DONE},
    '{MODE_INSERT, 32'h0000_0040, 1'b0, 1'b0, ST_DONE},
    '{MODE_INSERT, 32'hAAAA_AAA0, 1'b0, 1'b0, ST_DONE},
    '{MODE_INSERT, 32'h5555_5550, 1'b0, 1'b0, ST_DONE},
    '{MODE_INSERT, 32'hFFFF_FFF0, 1'b0, 1'b0, ST_DONE},      // ... eighth slot taken
    '{MODE_INSERT, 32'h0000_0100, 1'b1, 1'b0, ST_FULL},      // bucket full
    '{MODE_INSERT, 32'h8000_0000, 1'b1, 1'b1, ST_NOCHANGE},  // stored beats full
    '{MODE_ERASE,  32'h0000_0010, 1'b1, 1'b1, ST_DONE},
    '{MODE_INSERT, 32'h0000_0100, 1'b1, 1'b0, ST_DONE},      // reuses freed slot
    '{MODE_ERASE,  32'h0000_0010, 1'b1, 1'b0, ST_NOCHANGE},
    '{MODE_LOOKUP, 32'h0000_0100, 1'b1, 1'b1, ST_DONE},
    '{MODE_LOOKUP, 32'h0000_0010, 1'b0, 1'b0, ST_DONE},
    '{MODE_ERASE,  32'hFFFF_FFFF, 1'b1, 1'b1, ST_DONE},
    '{MODE_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_DONE},
    '{MODE_LOOKUP, 32'h0000_000F, 1'b1, 1'b0, ST_DONE}       // same bucket, other key
  };

  // Bucket-count settings, one per random phase.
  // The first two writes are out of range, below and above, and must be clamped.
  localparam logic [CFG_W-1:0] INDEX_PLAN [12] = '{
    4'd0, 4'd15, 4'd1, 4'd8, 4'd9, 4'd2, 4'd7, 4'd3, 4'd5, 4'd6, 4'd4, 4'd14
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  // Shadow of the set contents and the active bucket count
  logic [IN_KEY_W-1:0] shadow_key [NUM_BUCKETS][SLOTS];
  logic [SLOTS-1:0]    shadow_valid [NUM_BUCKETS];
  int unsigned         shadow_bits;

  out_item_t           answer_q [$];     // answers still owed by the block, oldest first
  int unsigned         bad_answers;
  bit                  calm;
  logic [IN_KEY_W-1:0] key_pool [POOL_SIZE];

  chained_hash_set_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one request to the shadow set and return the answer it should produce.
  function automatic out_item_t predict_access(in_item_t req);
    logic [7:0]       bkt;
    logic [SLOTS-1:0] vmask;
    int               hit;
    int               free_slot;
    out_item_t        ans;
    bkt       = 8'(req.key & ((32'd1 << shadow_bits) - 32'd1));
    vmask     = shadow_valid[bkt];
    hit       = -1;
    free_slot = -1;
    for (int s = 0; s < SLOTS; s++) begin
      if (vmask[s] && hit < 0 && shadow_key[bkt][s] == req.key) hit = s;
      if (!vmask[s] && free_slot < 0) free_slot = s;
    end
    ans.present = (hit >= 0);
    ans.status  = ST_DONE;
    case (req.mode)
      MODE_INSERT: begin
        if (hit >= 0) begin
          ans.status = ST_NOCHANGE;
        end else if (free_slot < 0) begin
          ans.status = ST_FULL;
        end else begin
          shadow_key[bkt][free_slot]   = req.key;
          shadow_valid[bkt][free_slot] = 1'b1;
        end
      end
      MODE_ERASE: begin
        if (hit >= 0) shadow_valid[bkt][hit] = 1'b0;
        else ans.status = ST_NOCHANGE;
      end
      default: ;  // lookup and the spare mode change nothing
    endcase
    return ans;
  endfunction

  function automatic void clear_shadow();
    foreach (shadow_valid[b]) shadow_valid[b] = '0;
  endfunction

  // Gap length: half the time none, mostly short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Keys are packed into at most four neighboring buckets.
  // This way the random phases reach hits, full buckets and slot reuse.
  function automatic void fill_key_pool();
    int unsigned         nb;
    int unsigned         lanes;
    int unsigned         base;
    logic [IN_KEY_W-1:0] low_mask;
    nb       = 1 << shadow_bits;
    lanes    = (nb < 4) ? nb : 4;
    base     = $urandom_range(0, nb - 1);
    low_mask = IN_KEY_W'(nb - 1);
    foreach (key_pool[i]) begin
      key_pool[i] = ($urandom() & ~low_mask)
                  | (IN_KEY_W'(base + $urandom_range(0, lanes - 1)) & low_mask);
    end
  endfunction

  // Insert-heavy mix, so the buckets fill up between erases.
  // A few fully random keys are mixed in as noise.
  function automatic in_item_t random_request();
    in_item_t    req;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45)      req.mode = MODE_INSERT;
    else if (r < 70) req.mode = MODE_LOOKUP;
    else if (r < 95) req.mode = MODE_ERASE;
    else             req.mode = MODE_SPARE;
    if ($urandom_range(0, 99) < 85) req.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else req.key = $urandom();
    return req;
  endfunction

  // Present one item and hold it until it is accepted.
  // The owed answer is queued at the accepting edge.
  task automatic offer_item(input in_item_t req, input bit typed, input out_item_t fixed);
    out_item_t ans;
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ans = predict_access(req);
    answer_q.push_back(typed ? fixed : ans);
  endtask

  task automatic hold_in(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every owed answer has come back.
  // Then let the block go idle.
  task automatic drain_answers();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Each write also clears the store. Out-of-range values are clamped.
  task automatic write_index_bits(input logic [CFG_W-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (value < 1) shadow_bits = 1;
    else if (value > MAX_INDEX_BITS) shadow_bits = MAX_INDEX_BITS;
    else shadow_bits = value;
    clear_shadow();
  endtask

  // Answer checker: values are taken at the edge, before the block updates them.
  always @(posedge clk) begin
    out_item_t want;
    if (out_valid === 1'b1 && out_ready) begin
      if (answer_q.size() == 0) begin
        $error("out_data: answer with none owed (present %0d, status %0d)",
               out_data.present, out_data.status);
        bad_answers++;
      end else begin
        want = answer_q.pop_front();
        if (out_data.present !== want.present) begin
          $error("present: expected %0d, actual %0d", want.present, out_data.present);
          bad_answers++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          bad_answers++;
        end
      end
    end
  end

  // Result side: the ready line alternates between runs of ready and stalls of random length.
  // In the calm phase it stays high.
  initial begin
    int unsigned hold;
    bit          rdy;
    out_ready <= 1'b0;
    rdy  = 1'b0;
    hold = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      if (hold != 0) begin
        hold--;
      end else if (rdy && !calm) begin
        rdy       = 1'b0;
        out_ready <= 1'b0;
        hold      = idle_len() + 1;
      end else begin
        rdy       = 1'b1;
        out_ready <= 1'b1;
        hold      = $urandom_range(1, 12);
      end
      @(posedge clk);
    end
  end

  // Request side and run control
  initial begin
    in_item_t  req;
    out_item_t fixed;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    bad_answers = 0;
    calm        = 1'b0;
    shadow_bits = INDEX_BITS_RESET;
    clear_shadow();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    // The block clears its valid masks after reset. in_ready stays low until it is done.

    foreach (DIR_ROWS[i]) begin
      req.mode      = DIR_ROWS[i].mode;
      req.key       = DIR_ROWS[i].key;
      fixed.present = DIR_ROWS[i].present;
      fixed.status  = DIR_ROWS[i].status;
      offer_item(req, DIR_ROWS[i].typed, fixed);
      hold_in(idle_len());
    end

    foreach (INDEX_PLAN[p]) begin
      // Registers change only once the block is idle.
      drain_answers();
      write_index_bits(INDEX_PLAN[p]);
      calm = (p == CALM_PHASE);
      fill_key_pool();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        offer_item(random_request(), 1'b0, '0);
        // Occasionally stop mid-phase until every answer is back.
        if ((p == 1 && k == PHASE_ITEMS / 2) || $urandom_range(0, 249) == 0) drain_answers();
        else if (!calm) hold_in(idle_len());
      end
    end

    drain_answers();
    if (bad_answers == 0 && answer_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: this is several times the slowest legal run.
  initial begin
    #(WATCHDOG_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
